// ===== hw/rtl/trn_pkg.sv =====
package trn_pkg;

   localparam int SUB_BUF_SIZE = 256;
   localparam int SUB_CNT_W    = $clog2(SUB_BUF_SIZE + 1);
   localparam int SUB_LEN_W    = 9;
   localparam int MAX_RES      = 4;
   localparam int RES_IDX_W    = $clog2(MAX_RES);
   localparam int RES_CNT_W    = $clog2(MAX_RES + 1);

   // telnet command bytes
   localparam logic [7:0] B_IAC  = 8'hff;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_DM   = 8'd242;
   localparam logic [7:0] B_SE   = 8'd240;
   localparam logic [7:0] B_NUL  = 8'd0;
   localparam logic [7:0] B_LF   = 8'd10;
   localparam logic [7:0] B_CR   = 8'd13;

   // option numbers
   localparam logic [7:0] OPT_BINARY = 8'd0;
   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;
   localparam logic [7:0] OPT_TM     = 8'd6;
   localparam logic [7:0] OPT_TTYPE  = 8'd24;
   localparam logic [7:0] OPT_NAWS   = 8'd31;
   localparam logic [7:0] OPT_TSPEED = 8'd32;
   localparam logic [7:0] OPT_LFLOW  = 8'd33;

   // option table entry bits
   localparam logic [3:0] HE_WILL = 4'b0001;
   localparam logic [3:0] HE_DO   = 4'b0010;
   localparam logic [3:0] ME_WILL = 4'b0100;
   localparam logic [3:0] ME_DO   = 4'b1000;

   // input commands
   localparam logic [2:0] CMD_RX   = 3'd0;
   localparam logic [2:0] CMD_DO   = 3'd1;
   localparam logic [2:0] CMD_DONT = 3'd2;
   localparam logic [2:0] CMD_WILL = 3'd3;
   localparam logic [2:0] CMD_WONT = 3'd4;

   // result kinds and event codes
   localparam logic [1:0] KIND_TTY = 2'd0;
   localparam logic [1:0] KIND_NET = 2'd1;
   localparam logic [1:0] KIND_EVT = 2'd2;

   localparam logic [1:0] EVT_SYNCH = 2'd0;
   localparam logic [1:0] EVT_TM    = 2'd1;
   localparam logic [1:0] EVT_SUB   = 2'd2;
   localparam logic [1:0] EVT_NAWS  = 2'd3;

   typedef struct packed {
      logic [1:0]           kind;
      logic [7:0]           data;
      logic [1:0]           code;
      logic [7:0]           opt;
      logic [7:0]           qual;
      logic [SUB_LEN_W-1:0] len;
      logic                 flow;
   } result_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [3:0] data;
   } tbl_wr_type;

endpackage

// ===== hw/rtl/trn_opt_table.sv =====
module trn_opt_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [7:0]         rd_addr,
   input  trn_pkg::tbl_wr_type wr,
   output logic [3:0]         rd_data,
   output logic               bin_he_will,
   output logic               echo_he_will
);

   logic [3:0] mem [256];
   logic [3:0] rd_ff;
   logic       rvld_ff;
   logic [255:0] vld_ff;
   logic       bin_ff;
   logic       echo_ff;
   logic       hit;

   assign hit = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         // forward a write landing on the same entry at this edge
         rd_ff <= hit ? wr.data : mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
         bin_ff  <= 1'b0;
         echo_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
            if (wr.addr == trn_pkg::OPT_BINARY) begin
               bin_ff <= wr.data[0];
            end
            if (wr.addr == trn_pkg::OPT_ECHO) begin
               echo_ff <= wr.data[0];
            end
         end
         if (rd_en) begin
            rvld_ff <= hit | vld_ff[rd_addr];
         end
      end
   end

   assign rd_data      = rvld_ff ? rd_ff : 4'b0000;
   assign bin_he_will  = bin_ff;
   assign echo_he_will = echo_ff;

endmodule

// ===== hw/rtl/trn_rx_core.sv =====
module trn_rx_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [2:0]             cmd,
   input  logic [7:0]             data_byte,
   input  logic [3:0]             tbl_entry,
   input  logic                   bin_he_will,
   input  logic                   echo_he_will,
   input  logic                   cr_to_crlf,
   output trn_pkg::tbl_wr_type    tbl_wr,
   output trn_pkg::result_type    res [trn_pkg::MAX_RES],
   output logic [trn_pkg::RES_CNT_W-1:0] res_n
);

   typedef enum logic [3:0] {
      PH_DATA, PH_IAC, PH_WILL, PH_WONT, PH_DO, PH_DONT, PH_CR, PH_SB, PH_SE
   } phase_type;

   typedef struct packed {
      logic [trn_pkg::SUB_CNT_W-1:0] cnt;
      logic [7:0]                    first;
      logic [7:0]                    second;
   } sub_type;

   typedef struct packed {
      logic       send;
      logic [3:0] v;
   } neg_type;

   phase_type phase_ff, phase_in;
   sub_type   sub_ff, sub_in;
   logic      flow_ff, flow_in;

   function automatic neg_type negotiate(input logic [3:0] v, input logic [7:0] verb);
      neg_type r;
      r.send = 1'b0;
      r.v    = v;
      unique case (verb)
         trn_pkg::B_DO: begin
            r.send = !((v & trn_pkg::HE_WILL) != 4'b0 && (v & trn_pkg::ME_DO) != 4'b0);
            r.v    = v | trn_pkg::ME_DO;
         end
         trn_pkg::B_DONT: begin
            r.send = (v & (trn_pkg::HE_WILL | trn_pkg::ME_DO)) != 4'b0;
            r.v    = v & ~trn_pkg::ME_DO;
         end
         trn_pkg::B_WILL: begin
            r.send = !((v & trn_pkg::HE_DO) != 4'b0 && (v & trn_pkg::ME_WILL) != 4'b0);
            r.v    = v | trn_pkg::ME_WILL;
         end
         default: begin
            r.send = (v & (trn_pkg::HE_DO | trn_pkg::ME_WILL)) != 4'b0;
            r.v    = v & ~trn_pkg::ME_WILL;
         end
      endcase
      return r;
   endfunction

   function automatic sub_type sub_put(input sub_type s, input logic [7:0] c);
      sub_type r;
      r = s;
      if (s.cnt < trn_pkg::SUB_CNT_W'(trn_pkg::SUB_BUF_SIZE)) begin
         if (s.cnt == '0) begin
            r.first = c;
         end else if (s.cnt == trn_pkg::SUB_CNT_W'(1)) begin
            r.second = c;
         end
         r.cnt = s.cnt + trn_pkg::SUB_CNT_W'(1);
      end
      return r;
   endfunction

   function automatic trn_pkg::result_type mk(input logic [1:0] kind, input logic [7:0] b,
                                               input logic [1:0] code, input logic [7:0] opt,
                                               input logic [7:0] qual,
                                               input logic [trn_pkg::SUB_LEN_W-1:0] len);
      trn_pkg::result_type r;
      r.kind = kind;
      r.data = b;
      r.code = code;
      r.opt  = opt;
      r.qual = qual;
      r.len  = len;
      r.flow = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic [7:0]   c;
      logic [3:0]   v;
      logic [7:0]   verb;
      logic         neg_en;
      logic         data_in;
      neg_type      nr;
      logic [trn_pkg::RES_CNT_W-1:0] n;
      trn_pkg::result_type r [trn_pkg::MAX_RES];

      c        = data_byte;
      v        = tbl_entry;
      verb     = trn_pkg::B_DO;
      neg_en   = 1'b0;
      data_in  = 1'b0;
      n        = '0;
      phase_in = phase_ff;
      sub_in   = sub_ff;
      flow_in  = flow_ff;
      for (int i = 0; i < trn_pkg::MAX_RES; i++) begin
         r[i] = '0;
      end

      unique case (cmd)
         trn_pkg::CMD_DO: begin
            neg_en = 1'b1;
            verb   = trn_pkg::B_DO;
         end
         trn_pkg::CMD_DONT: begin
            neg_en = 1'b1;
            verb   = trn_pkg::B_DONT;
         end
         trn_pkg::CMD_WILL: begin
            neg_en = 1'b1;
            verb   = trn_pkg::B_WILL;
         end
         trn_pkg::CMD_WONT: begin
            neg_en = 1'b1;
            verb   = trn_pkg::B_WONT;
         end
         trn_pkg::CMD_RX: begin
            unique case (phase_ff)
               PH_CR: begin
                  phase_in = PH_DATA;
                  if (c == trn_pkg::B_NUL) begin
                     r[n[trn_pkg::RES_IDX_W-1:0]] = mk(trn_pkg::KIND_TTY, trn_pkg::B_CR,
                                                       '0, '0, '0, '0);
                     n = n + 1'b1;
                  end else if (c == trn_pkg::B_LF && !echo_he_will) begin
                     r[n[trn_pkg::RES_IDX_W-1:0]] = mk(trn_pkg::KIND_TTY, trn_pkg::B_LF,
                                                       '0, '0, '0, '0);
                     n = n + 1'b1;
                  end else begin
                     r[n[trn_pkg::RES_IDX_W-1:0]] = mk(trn_pkg::KIND_TTY, trn_pkg::B_CR,
                                                       '0, '0, '0, '0);
                     n = n + 1'b1;
                     if (cr_to_crlf) begin
                        r[n[trn_pkg::RES_IDX_W-1:0]] = mk(trn_pkg::KIND_TTY, trn_pkg::B_LF,
                                                          '0, '0, '0, '0);
                        n = n + 1'b1;
                     end
                     data_in = 1'b1;
                  end
               end
               PH_IAC: begin
                  phase_in = PH_DATA;
                  if (c == trn_pkg::B_WILL) begin
                     phase_in = PH_WILL;
                  end else if (c == trn_pkg::B_WONT) begin
                     phase_in = PH_WONT;
                  end else if (c == trn_pkg::B_DO) begin
                     phase_in = PH_DO;
                  end else if (c == trn_pkg::B_DONT) begin
                     phase_in = PH_DONT;
                  end else if (c == trn_pkg::B_SB) begin
                     sub_in   = '0;
                     phase_in = PH_SB;
                  end else if (c == trn_pkg::B_DM) begin
                     r[0] = mk(trn_pkg::KIND_EVT, '0, trn_pkg::EVT_SYNCH, '0, '0, '0);
                     n    = trn_pkg::RES_CNT_W'(1);
                  end else if (c == trn_pkg::B_IAC) begin
                     r[0] = mk(trn_pkg::KIND_TTY, trn_pkg::B_IAC, '0, '0, '0, '0);
                     n    = trn_pkg::RES_CNT_W'(1);
                  end
               end
               PH_WILL, PH_WONT: begin
                  phase_in = PH_DATA;
                  if (c == trn_pkg::OPT_TM) begin
                     r[0] = mk(trn_pkg::KIND_EVT, '0, trn_pkg::EVT_TM, trn_pkg::OPT_TM,
                               '0, '0);
                     n    = trn_pkg::RES_CNT_W'(1);
                  end else begin
                     neg_en = 1'b1;
                     if (phase_ff == PH_WILL) begin
                        v    = v | trn_pkg::HE_WILL;
                        verb = (c == trn_pkg::OPT_SGA || c == trn_pkg::OPT_ECHO) ?
                               trn_pkg::B_DO : trn_pkg::B_DONT;
                     end else begin
                        v    = v & ~trn_pkg::HE_WILL;
                        verb = trn_pkg::B_DONT;
                     end
                  end
               end
               PH_DO: begin
                  phase_in = PH_DATA;
                  neg_en   = 1'b1;
                  v        = v | trn_pkg::HE_DO;
                  verb     = (c == trn_pkg::OPT_TM || c == trn_pkg::OPT_NAWS ||
                              c == trn_pkg::OPT_TSPEED || c == trn_pkg::OPT_LFLOW ||
                              c == trn_pkg::OPT_TTYPE || c == trn_pkg::OPT_SGA) ?
                             trn_pkg::B_WILL : trn_pkg::B_WONT;
                  if (c == trn_pkg::OPT_LFLOW) begin
                     flow_in = 1'b1;
                  end
               end
               PH_DONT: begin
                  phase_in = PH_DATA;
                  neg_en   = 1'b1;
                  v        = v & ~trn_pkg::HE_DO;
                  verb     = trn_pkg::B_WONT;
               end
               PH_SB: begin
                  if (c == trn_pkg::B_IAC) begin
                     phase_in = PH_SE;
                  end else begin
                     sub_in = sub_put(sub_ff, c);
                  end
               end
               PH_SE: begin
                  if (c != trn_pkg::B_SE) begin
                     if (c != trn_pkg::B_IAC) begin
                        sub_in = sub_put(sub_ff, trn_pkg::B_IAC);
                     end
                     sub_in   = sub_put(sub_in, c);
                     phase_in = PH_SB;
                  end else begin
                     phase_in = PH_DATA;
                     if (sub_ff.cnt >= trn_pkg::SUB_CNT_W'(2) &&
                         sub_ff.first == trn_pkg::OPT_LFLOW) begin
                        if (sub_ff.second == 8'd1) begin
                           flow_in = 1'b1;
                        end else if (sub_ff.second == 8'd0) begin
                           flow_in = 1'b0;
                        end
                     end
                     r[0] = mk(trn_pkg::KIND_EVT, '0, trn_pkg::EVT_SUB, sub_ff.first,
                               sub_ff.second, trn_pkg::SUB_LEN_W'(sub_ff.cnt));
                     n    = trn_pkg::RES_CNT_W'(1);
                  end
               end
               default: begin
                  phase_in = PH_DATA;
                  data_in  = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase

      // plain data byte handling, also after a released cr
      if (data_in) begin
         if (c == trn_pkg::B_IAC) begin
            phase_in = PH_IAC;
         end else if (c == trn_pkg::B_CR && !bin_he_will) begin
            phase_in = PH_CR;
         end else begin
            r[n[trn_pkg::RES_IDX_W-1:0]] = mk(trn_pkg::KIND_TTY, c, '0, '0, '0, '0);
            n = n + 1'b1;
         end
      end

      nr = negotiate(v, verb);
      if (neg_en && nr.send) begin
         r[0] = mk(trn_pkg::KIND_NET, trn_pkg::B_IAC, '0, '0, '0, '0);
         r[1] = mk(trn_pkg::KIND_NET, verb, '0, '0, '0, '0);
         r[2] = mk(trn_pkg::KIND_NET, c, '0, '0, '0, '0);
         n    = trn_pkg::RES_CNT_W'(3);
      end
      if (cmd == trn_pkg::CMD_RX && phase_ff == PH_DO && c == trn_pkg::OPT_NAWS) begin
         r[n[trn_pkg::RES_IDX_W-1:0]] = mk(trn_pkg::KIND_EVT, '0, trn_pkg::EVT_NAWS,
                                           '0, '0, '0);
         n = n + 1'b1;
      end

      for (int i = 0; i < trn_pkg::MAX_RES; i++) begin
         r[i].flow = flow_in;
         res[i]    = r[i];
      end
      res_n       = n;
      tbl_wr.en   = fire && neg_en;
      tbl_wr.addr = c;
      tbl_wr.data = nr.v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DATA;
         sub_ff   <= '0;
         flow_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         sub_ff   <= sub_in;
         flow_ff  <= flow_in;
      end
   end

endmodule

// ===== hw/rtl/trn_rsp_queue.sv =====
module trn_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  trn_pkg::result_type    res [trn_pkg::MAX_RES],
   input  logic [trn_pkg::RES_CNT_W-1:0] res_n,
   output logic                   room,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output trn_pkg::result_type    head,
   output logic                   head_last
);

   trn_pkg::result_type res_ff [trn_pkg::MAX_RES];
   logic [trn_pkg::RES_CNT_W-1:0] cnt_ff;
   logic take;

   assign take       = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != '0;
   assign room       = (cnt_ff == '0) || (cnt_ff == trn_pkg::RES_CNT_W'(1) && rsp_tready);
   assign head       = res_ff[0];
   assign head_last  = cnt_ff == trn_pkg::RES_CNT_W'(1);

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end else if (take) begin
         for (int i = 0; i < trn_pkg::MAX_RES - 1; i++) begin
            res_ff[i] <= res_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= res_n;
      end else if (take) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= trn_pkg::RES_CNT_W'(trn_pkg::MAX_RES))
      else $error("result queue count out of range");

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      load |-> room)
      else $error("results loaded over pending ones");

endmodule

// ===== hw/rtl/telnet_receive_negotiator_unit.sv =====
// Telnet receive side with option negotiation. Each transfer on req_ carries either a received
// network byte (cmd 0) or a local DO/DONT/WILL/WONT request; it produces zero to four
// result transfers on rsp_, terminal bytes, network reply bytes or event reports, the last
// marked by rsp_tlast. An item passes an input register and the combinational core, then its
// results leave one per cycle while rsp_tready is high, from a four-entry output queue;
// the queue drain sets the rate. Unless the peer WILL BINARY, a received CR is held back until the
// next received byte decides how it is delivered. csr_data sets cr_to_crlf; write it only
// while the block is idle. The 256-entry option table is a memory with per-entry valid
// bits, so no clearing pass is needed after reset.
module telnet_receive_negotiator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cmd[2:0], data_byte[10:3], zero[15:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_byte, event_code, event_option, sub_qualifier,
                                    // sub_length, local_flow, zero pad
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_data     // cr_to_crlf
);

   logic       in_vld_ff;
   logic [2:0] in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       crlf_ff;
   logic       fire;
   logic       room;
   logic       accept;
   logic [3:0] tbl_entry;
   logic       bin_he_will;
   logic       echo_he_will;
   trn_pkg::tbl_wr_type tbl_wr;
   trn_pkg::result_type res [trn_pkg::MAX_RES];
   logic [trn_pkg::RES_CNT_W-1:0] res_n;
   trn_pkg::result_type head;

   assign fire       = in_vld_ff && room;
   assign req_tready = !in_vld_ff || fire;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= req_tdata[2:0];
         in_byte_ff <= req_tdata[10:3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         crlf_ff   <= 1'b0;
      end else begin
         if (accept) begin
            in_vld_ff <= 1'b1;
         end else if (fire) begin
            in_vld_ff <= 1'b0;
         end
         if (csr_valid) begin
            crlf_ff <= csr_data[0];
         end
      end
   end

   trn_opt_table u_table (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (accept),
      .rd_addr      (req_tdata[10:3]),
      .wr           (tbl_wr),
      .rd_data      (tbl_entry),
      .bin_he_will  (bin_he_will),
      .echo_he_will (echo_he_will)
   );

   trn_rx_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .cmd          (in_cmd_ff),
      .data_byte    (in_byte_ff),
      .tbl_entry    (tbl_entry),
      .bin_he_will  (bin_he_will),
      .echo_he_will (echo_he_will),
      .cr_to_crlf   (crlf_ff),
      .tbl_wr       (tbl_wr),
      .res          (res),
      .res_n        (res_n)
   );

   trn_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .res        (res),
      .res_n      (res_n),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head),
      .head_last  (rsp_tlast)
   );

   assign rsp_tuser = head.kind;
   assign rsp_tdata = {4'b0000, head.flow, head.len, head.qual, head.opt, head.code, head.data};

   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_vld_ff)
      else $error("accepted item not held in input register");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_vld_ff && !room))
      else $error("input stalled without a waiting item");

   a_tbl_wr_fire: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> fire)
      else $error("option table written outside item commit");

endmodule

// ===== tb/telnet_receive_negotiator_checker.sv =====
module telnet_receive_negotiator_checker
   import trn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_data,
   output int          errors,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      ST_DATA, ST_IAC, ST_WILL, ST_WONT, ST_DO, ST_DONT, ST_CR, ST_SB, ST_SE
   } rx_state_type;

   typedef struct packed {
      result_type res;
      logic       last;
   } reply_type;

   logic [3:0]   opt_tbl [256];
   rx_state_type rx_st;
   int           sub_cnt;
   logic [7:0]   sub_opt, sub_qual;
   logic         flow, crlf;
   reply_type    replies_due[$];
   result_type   step_res [MAX_RES];
   int           step_n;

   initial begin
      errors = 0;
      outstanding = 0;
   end

   function automatic void put(logic [1:0] k, logic [7:0] d, logic [1:0] c = 2'd0,
                               logic [7:0] o = 8'd0, logic [7:0] q = 8'd0,
                               logic [SUB_LEN_W-1:0] l = '0);
      if (step_n >= MAX_RES) return;
      step_res[step_n] = '{kind: k, data: d, code: c, opt: o, qual: q, len: l, flow: 1'b0};
      step_n++;
   endfunction

   function automatic void to_tty(logic [7:0] b);
      put(KIND_TTY, b);
   endfunction

   function automatic void to_net(logic [7:0] verb, logic [7:0] o);
      put(KIND_NET, B_IAC);
      put(KIND_NET, verb);
      put(KIND_NET, o);
   endfunction

   function automatic void ask_do(logic [7:0] o);
      logic [3:0] v;
      v = opt_tbl[o];
      if (!((v & HE_WILL) != 0 && (v & ME_DO) != 0)) to_net(B_DO, o);
      opt_tbl[o] = v | ME_DO;
   endfunction

   function automatic void ask_dont(logic [7:0] o);
      logic [3:0] v;
      v = opt_tbl[o];
      if ((v & (HE_WILL | ME_DO)) != 0) to_net(B_DONT, o);
      opt_tbl[o] = v & ~ME_DO;
   endfunction

   function automatic void ask_will(logic [7:0] o);
      logic [3:0] v;
      v = opt_tbl[o];
      if (!((v & HE_DO) != 0 && (v & ME_WILL) != 0)) to_net(B_WILL, o);
      opt_tbl[o] = v | ME_WILL;
   endfunction

   function automatic void ask_wont(logic [7:0] o);
      logic [3:0] v;
      v = opt_tbl[o];
      if ((v & (HE_DO | ME_WILL)) != 0) to_net(B_WONT, o);
      opt_tbl[o] = v & ~ME_WILL;
   endfunction

   function automatic void collect(logic [7:0] c);
      if (sub_cnt >= SUB_BUF_SIZE) return;
      if (sub_cnt == 0) sub_opt = c;
      else if (sub_cnt == 1) sub_qual = c;
      sub_cnt++;
   endfunction

   function automatic void plain_byte(logic [7:0] c);
      if (c == B_IAC) rx_st = ST_IAC;
      else if (c == B_CR && (opt_tbl[OPT_BINARY] & HE_WILL) == 0) rx_st = ST_CR;
      else to_tty(c);
   endfunction

   function automatic void receive(logic [7:0] c);
      case (rx_st)
         ST_CR: begin
            rx_st = ST_DATA;
            if (c == B_NUL) to_tty(B_CR);
            else if (c == B_LF && (opt_tbl[OPT_ECHO] & HE_WILL) == 0) to_tty(B_LF);
            else begin
               to_tty(B_CR);
               if (crlf) to_tty(B_LF);
               plain_byte(c);
            end
         end
         ST_IAC: begin
            rx_st = ST_DATA;
            if (c == B_WILL) rx_st = ST_WILL;
            else if (c == B_WONT) rx_st = ST_WONT;
            else if (c == B_DO) rx_st = ST_DO;
            else if (c == B_DONT) rx_st = ST_DONT;
            else if (c == B_SB) begin
               sub_cnt = 0;
               sub_opt = '0;
               sub_qual = '0;
               rx_st = ST_SB;
            end else if (c == B_DM) put(KIND_EVT, 8'd0, EVT_SYNCH);
            else if (c == B_IAC) to_tty(B_IAC);
         end
         ST_WILL: begin
            rx_st = ST_DATA;
            if (c == OPT_TM) put(KIND_EVT, 8'd0, EVT_TM, OPT_TM);
            else begin
               opt_tbl[c] = opt_tbl[c] | HE_WILL;
               if (c == OPT_SGA || c == OPT_ECHO) ask_do(c);
               else ask_dont(c);
            end
         end
         ST_WONT: begin
            rx_st = ST_DATA;
            if (c == OPT_TM) put(KIND_EVT, 8'd0, EVT_TM, OPT_TM);
            else begin
               opt_tbl[c] = opt_tbl[c] & ~HE_WILL;
               ask_dont(c);
            end
         end
         ST_DO: begin
            rx_st = ST_DATA;
            opt_tbl[c] = opt_tbl[c] | HE_DO;
            if (c == OPT_TM || c == OPT_NAWS || c == OPT_TSPEED || c == OPT_LFLOW ||
                c == OPT_TTYPE || c == OPT_SGA) ask_will(c);
            else ask_wont(c);
            if (c == OPT_NAWS) put(KIND_EVT, 8'd0, EVT_NAWS);
            else if (c == OPT_LFLOW) flow = 1'b1;
         end
         ST_DONT: begin
            rx_st = ST_DATA;
            opt_tbl[c] = opt_tbl[c] & ~HE_DO;
            ask_wont(c);
         end
         ST_SB: begin
            if (c == B_IAC) rx_st = ST_SE;
            else collect(c);
         end
         ST_SE: begin
            if (c != B_SE) begin
               // escaped iac or stray command byte stays in the buffer
               if (c != B_IAC) collect(B_IAC);
               collect(c);
               rx_st = ST_SB;
            end else begin
               rx_st = ST_DATA;
               if (sub_cnt >= 2 && sub_opt == OPT_LFLOW) begin
                  if (sub_qual == 8'd1) flow = 1'b1;
                  else if (sub_qual == 8'd0) flow = 1'b0;
               end
               put(KIND_EVT, 8'd0, EVT_SUB, sub_opt, sub_qual, sub_cnt[SUB_LEN_W-1:0]);
            end
         end
         default: begin
            rx_st = ST_DATA;
            plain_byte(c);
         end
      endcase
   endfunction

   function automatic void negotiate_step(logic [2:0] cmd, logic [7:0] b);
      reply_type r;
      step_n = 0;
      case (cmd)
         CMD_RX:   receive(b);
         CMD_DO:   ask_do(b);
         CMD_DONT: ask_dont(b);
         CMD_WILL: ask_will(b);
         CMD_WONT: ask_wont(b);
         default: ;
      endcase
      for (int k = 0; k < step_n; k++) begin
         r.res = step_res[k];
         r.res.flow = flow;
         r.last = (k == step_n - 1);
         replies_due.push_back(r);
      end
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      reply_type w;
      if (reset) begin
         foreach (opt_tbl[i]) opt_tbl[i] = '0;
         rx_st = ST_DATA;
         sub_cnt = 0;
         sub_opt = '0;
         sub_qual = '0;
         flow = 1'b0;
         crlf = 1'b0;
         replies_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) report("unexpected transfer", rsp_tdata, 0);
            else begin
               w = replies_due.pop_front();
               if (rsp_tuser != w.res.kind) report("kind", rsp_tuser, w.res.kind);
               if (rsp_tdata[7:0] != w.res.data) report("out_byte", rsp_tdata[7:0], w.res.data);
               if (rsp_tdata[9:8] != w.res.code) report("event_code", rsp_tdata[9:8], w.res.code);
               if (rsp_tdata[17:10] != w.res.opt)
                  report("event_option", rsp_tdata[17:10], w.res.opt);
               if (rsp_tdata[25:18] != w.res.qual)
                  report("sub_qualifier", rsp_tdata[25:18], w.res.qual);
               if (rsp_tdata[34:26] != w.res.len)
                  report("sub_length", rsp_tdata[34:26], w.res.len);
               if (rsp_tdata[35] != w.res.flow) report("local_flow", rsp_tdata[35], w.res.flow);
               if (rsp_tlast != w.last) report("last", rsp_tlast, w.last);
            end
         end
         if (csr_valid && csr_ready) crlf = csr_data[0];
         if (req_tvalid && req_tready) negotiate_step(req_tdata[2:0], req_tdata[10:3]);
      end
      outstanding = replies_due.size();
   end

endmodule

// ===== tb/telnet_receive_negotiator_unit_tb.sv =====
module telnet_receive_negotiator_unit_tb;
   import trn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_data = '0;

   int   errors, outstanding;
   int   cycles = 0;
   int   sent = 0;
   bit   calm = 0;
   bit   hold_go = 0;
   logic req_rdy_seen = 1'b0, csr_rdy_seen = 1'b0;

   telnet_receive_negotiator_unit u_dut (.*);

   telnet_receive_negotiator_checker u_chk (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ready levels settle well before the falling edge
   always @(negedge clock) begin
      req_rdy_seen <= req_tready;
      csr_rdy_seen <= csr_ready;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("telnet_receive_negotiator_unit_tb NOT OK");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_go = 0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 34);
         end
      end
   end

   task automatic send_item(logic [2:0] cmd, logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, b, cmd};
      do @(posedge clock); while (!req_rdy_seen);
      sent++;
      // idle cycles drawn one at a time, about a third of all cycles
      if (!calm) begin
         while ($urandom_range(99) < 34) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic rx(logic [7:0] b);
      send_item(CMD_RX, b);
   endtask

   task automatic command(logic [7:0] verb, logic [7:0] o);
      rx(B_IAC);
      rx(verb);
      rx(o);
   endtask

   task automatic subneg(int len, logic [7:0] o, logic [7:0] q);
      logic [7:0] b;
      rx(B_IAC);
      rx(B_SB);
      for (int i = 0; i < len; i++) begin
         b = (i == 0) ? o : (i == 1) ? q : 8'($urandom);
         rx(b);
         if (b == B_IAC) rx(($urandom_range(3) == 0) ? 8'($urandom) : B_IAC);
      end
      rx(B_IAC);
      rx(B_SE);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_crlf(logic v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_rdy_seen);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_opt();
      case ($urandom_range(9))
         0: return OPT_BINARY;
         1: return OPT_ECHO;
         2: return OPT_SGA;
         3: return OPT_TM;
         4: return OPT_TTYPE;
         5: return OPT_NAWS;
         6: return OPT_TSPEED;
         7: return OPT_LFLOW;
         8: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_verb();
      case ($urandom_range(3))
         0: return B_WILL;
         1: return B_WONT;
         2: return B_DO;
         default: return B_DONT;
      endcase
   endfunction

   task automatic random_traffic(int count);
      int stop;
      logic [7:0] q;
      stop = sent + count;
      while (sent < stop) begin
         case ($urandom_range(99)) inside
            [0:29]:  rx(8'($urandom));
            [30:41]: begin
               rx(B_CR);
               case ($urandom_range(3))
                  0: rx(B_NUL);
                  1: rx(B_LF);
                  2: rx(B_CR);
                  default: rx(8'($urandom));
               endcase
            end
            [42:61]: command(pick_verb(), pick_opt());
            [62:73]: send_item(3'($urandom_range(CMD_DO, CMD_WONT)), pick_opt());
            [74:83]: begin
               q = ($urandom_range(3) == 3) ? 8'($urandom) : 8'($urandom_range(2));
               subneg($urandom_range(6), $urandom_range(1) ? OPT_LFLOW : pick_opt(), q);
            end
            [84:90]: begin
               rx(B_IAC);
               case ($urandom_range(3))
                  0: rx(B_DM);
                  1: rx(B_IAC);
                  2: rx(8'd241);
                  default: rx(8'($urandom));
               endcase
            end
            [91:94]: send_item(3'($urandom_range(5, 7)), 8'($urandom));
            default: send_item(3'($urandom), 8'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_crlf(1'b0);

      // extremes, framing corners and a sample of negotiation paths
      rx(8'h00);
      rx(8'h7f);
      rx(B_CR); rx(B_NUL);
      rx(B_CR); rx(B_LF);
      rx(B_CR); rx(8'h41);
      rx(B_IAC); rx(B_IAC);
      rx(B_IAC); rx(B_DM);
      command(B_WILL, OPT_TM);
      command(B_DO, OPT_NAWS);
      command(B_DO, OPT_LFLOW);
      send_item(CMD_DO, 8'hff);
      send_item(CMD_WONT, 8'hff);
      send_item(3'd7, 8'hff);

      random_traffic(ITEMS_PER_PHASE);
      drain();
      write_crlf(1'b1);
      hold_go = 1;
      random_traffic(ITEMS_PER_PHASE);
      drain();

      // no idling on either side for this stretch, plus an overflowing subnegotiation
      calm = 1;
      write_crlf(1'b0);
      subneg(262, OPT_LFLOW, 8'd1);
      random_traffic(ITEMS_PER_PHASE);
      calm = 0;
      drain();
      write_crlf(1'b1);
      random_traffic(ITEMS_PER_PHASE);

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("telnet_receive_negotiator_unit_tb OK");
      end else begin
         $display("telnet_receive_negotiator_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/trn_pkg.sv
hw/rtl/trn_opt_table.sv
hw/rtl/trn_rx_core.sv
hw/rtl/trn_rsp_queue.sv
hw/rtl/telnet_receive_negotiator_unit.sv
tb/telnet_receive_negotiator_checker.sv
tb/telnet_receive_negotiator_unit_tb.sv
